[rtl/core/bss_pkg.sv]
package bss_pkg;

    localparam int unsigned MAX_BYTES = 8192;
    localparam int unsigned PosW      = $clog2(MAX_BYTES + 1);
    localparam int unsigned CountW    = 17;
    localparam int unsigned IndexW    = 16;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned VbW       = 4;
    localparam int unsigned BitW      = 3;

    localparam logic [VbW-1:0]   FULL_BYTE_BITS = VbW'(ByteW);
    localparam logic [ByteW-1:0] BYTE_ONES      = 8'hFF;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic [VbW-1:0]   valid_bits;
        logic             last;
    } scan_item_t;

    typedef struct packed {
        logic [CountW-1:0] set_count;
        logic [CountW-1:0] clear_count;
        logic              first_set_found;
        logic [IndexW-1:0] first_set_index;
        logic              first_clear_found;
        logic [IndexW-1:0] first_clear_index;
        logic              all_set;
        logic              all_clear;
        logic              overflow;
    } summary_item_t;

    function automatic logic [VbW-1:0] ones8(input logic [ByteW-1:0] v);
        logic [VbW-1:0] n;
        n = '0;
        for (int i = 0; i < ByteW; i++)
        begin
            n = n + VbW'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [BitW-1:0] lowest8(input logic [ByteW-1:0] v);
        logic [BitW-1:0] idx;
        idx = '0;
        for (int i = ByteW - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BitW'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/core/bss_scan_if.sv]
interface bss_scan_if
    import bss_pkg::*;
    ();
    logic       valid;
    logic       ready;
    scan_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/bss_summary_if.sv]
interface bss_summary_if
    import bss_pkg::*;
    ();
    logic          valid;
    logic          ready;
    summary_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/bitmap_scan_summary.sv]
// Bit array scan summary.
// The bytes channel takes one byte of a bit array per item, lowest bit index
// first, with a last flag and the number of valid bits in the final byte.
// The summary channel gives one item per array, after its last byte: set and
// clear counts, first set and first clear indices with found flags, all-set,
// all-clear and overflow. Bytes past MAX_BYTES are dropped and flag overflow.
// A byte enters an input register, then one pass of popcount, priority
// encode and accumulate updates the running state and, on the last byte,
// loads the result register. One byte is accepted every cycle, except while
// a last byte waits in the input register for the result register to free.
// When the receiver stalls, the result register holds its summary; bytes
// that are not last keep streaming, and a last byte waits in the input
// register until the result register frees up.
// Reset clears the running state and both valid flags.
module bitmap_scan_summary
    import bss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bss_scan_if.sink      bytes,
    bss_summary_if.source summary
);

    logic                  s1_valid_reg;
    scan_item_t            s1_item_reg;
    logic                  out_valid_reg;
    summary_item_t         out_item_reg;

    logic [CountW-1:0]     set_cnt_reg,   set_cnt_next;
    logic [CountW-1:0]     bit_tot_reg,   bit_tot_next;
    logic [PosW-1:0]       pos_reg,       pos_next;
    logic                  set_seen_reg,  set_seen_next;
    logic [IndexW-1:0]     set_pos_reg,   set_pos_next;
    logic                  clr_seen_reg,  clr_seen_next;
    logic [IndexW-1:0]     clr_pos_reg,   clr_pos_next;
    logic                  too_long_reg,  too_long_next;

    logic                  out_free;
    logic                  s2_fire;
    logic [VbW-1:0]        vb_eff;
    logic [ByteW-1:0]      mask;
    logic [ByteW-1:0]      sbits;
    logic [ByteW-1:0]      cbits;
    logic [IndexW+PosW+BitW-1:0] set_idx_wide;
    logic [IndexW+PosW+BitW-1:0] clr_idx_wide;
    logic [CountW-1:0]     clear_count;
    summary_item_t         result;

    assign out_free      = !out_valid_reg || summary.ready;
    assign s2_fire       = s1_valid_reg && (!s1_item_reg.last || out_free);
    assign bytes.ready   = !s1_valid_reg || s2_fire;
    assign summary.valid = out_valid_reg;
    assign summary.payload = out_item_reg;

    always_comb
    begin
        if (!s1_item_reg.last || s1_item_reg.valid_bits == '0
            || s1_item_reg.valid_bits > FULL_BYTE_BITS)
        begin
            vb_eff = FULL_BYTE_BITS;
        end
        else
        begin
            vb_eff = s1_item_reg.valid_bits;
        end
        mask  = BYTE_ONES >> (FULL_BYTE_BITS - vb_eff);
        sbits = s1_item_reg.data_byte & mask;
        cbits = ~s1_item_reg.data_byte & mask;
        set_idx_wide = {IndexW'(0), pos_reg, lowest8(sbits)};
        clr_idx_wide = {IndexW'(0), pos_reg, lowest8(cbits)};

        set_cnt_next  = set_cnt_reg;
        bit_tot_next  = bit_tot_reg;
        pos_next      = pos_reg;
        set_seen_next = set_seen_reg;
        set_pos_next  = set_pos_reg;
        clr_seen_next = clr_seen_reg;
        clr_pos_next  = clr_pos_reg;
        too_long_next = too_long_reg;

        if (pos_reg >= PosW'(MAX_BYTES))
        begin
            too_long_next = 1'b1;
        end
        else
        begin
            set_cnt_next = set_cnt_reg + CountW'(ones8(sbits));
            bit_tot_next = bit_tot_reg + CountW'(vb_eff);
            if (!set_seen_reg && sbits != '0)
            begin
                set_seen_next = 1'b1;
                set_pos_next  = set_idx_wide[IndexW-1:0];
            end
            if (!clr_seen_reg && cbits != '0)
            begin
                clr_seen_next = 1'b1;
                clr_pos_next  = clr_idx_wide[IndexW-1:0];
            end
            pos_next = pos_reg + PosW'(1);
        end

        clear_count = bit_tot_next - set_cnt_next;
        result.set_count         = set_cnt_next;
        result.clear_count       = clear_count;
        result.first_set_found   = set_seen_next;
        result.first_set_index   = set_seen_next ? set_pos_next : '0;
        result.first_clear_found = clr_seen_next;
        result.first_clear_index = clr_seen_next ? clr_pos_next : '0;
        result.all_set           = (clear_count == '0);
        result.all_clear         = (set_cnt_next == '0);
        result.overflow          = too_long_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            set_cnt_reg   <= '0;
            bit_tot_reg   <= '0;
            pos_reg       <= '0;
            set_seen_reg  <= 1'b0;
            set_pos_reg   <= '0;
            clr_seen_reg  <= 1'b0;
            clr_pos_reg   <= '0;
            too_long_reg  <= 1'b0;
        end
        else
        begin
            if (bytes.ready)
            begin
                s1_valid_reg <= bytes.valid;
            end
            if (summary.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s2_fire)
            begin
                if (s1_item_reg.last)
                begin
                    out_valid_reg <= 1'b1;
                    set_cnt_reg   <= '0;
                    bit_tot_reg   <= '0;
                    pos_reg       <= '0;
                    set_seen_reg  <= 1'b0;
                    set_pos_reg   <= '0;
                    clr_seen_reg  <= 1'b0;
                    clr_pos_reg   <= '0;
                    too_long_reg  <= 1'b0;
                end
                else
                begin
                    set_cnt_reg   <= set_cnt_next;
                    bit_tot_reg   <= bit_tot_next;
                    pos_reg       <= pos_next;
                    set_seen_reg  <= set_seen_next;
                    set_pos_reg   <= set_pos_next;
                    clr_seen_reg  <= clr_seen_next;
                    clr_pos_reg   <= clr_pos_next;
                    too_long_reg  <= too_long_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            s1_item_reg <= bytes.payload;
        end
        if (s2_fire && s1_item_reg.last)
        begin
            out_item_reg <= result;
        end
    end

endmodule
